[rtl/pitman_yor_table_seater_unit_assert.svh]
// Assertion macros for the Pitman-Yor table seater.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef PITMAN_YOR_TABLE_SEATER_UNIT_ASSERT_SVH
`define PITMAN_YOR_TABLE_SEATER_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define PYTS_ASSERT_HOLD(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define PYTS_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pyts_pkg.sv]
// Shared types and constants of the Pitman-Yor table seater.
// No dependencies; imported by the interfaces, store, top level and testbench.
package pyts_pkg;

    localparam int WORD_W    = 32;
    localparam int DISH_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 4;
    localparam int TIDX_W    = 6;
    localparam int FRAC_BITS = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CONCENTRATION = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT      = 4'd1;

    localparam logic [CFG_W-1:0] CONC_RESET = 16'd256;
    localparam logic [CFG_W-1:0] DISC_RESET = 16'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL_LO,
        S_MUL_HI,
        S_THR,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

[rtl/pyts_in_if.sv]
// Input channel of the table seater: one customer word per handshake.
// Depends on pyts_pkg for field widths.
interface pyts_in_if
    import pyts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] uniform_word;
    logic [DISH_W-1:0] base_dish;

    modport source (output valid, output uniform_word, output base_dish, input ready);
    modport sink   (input valid, input uniform_word, input base_dish, output ready);
endinterface

[rtl/pyts_out_if.sv]
// Result channel of the table seater: one seating word per handshake.
// Depends on pyts_pkg for field widths.
interface pyts_out_if
    import pyts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TIDX_W-1:0] table_index;
    logic [DISH_W-1:0] dish_value;
    logic              opened_new;
    logic              store_full;

    modport source (output valid, output table_index, output dish_value,
                    output opened_new, output store_full, input ready);
    modport sink   (input valid, input table_index, input dish_value,
                    input opened_new, input store_full, output ready);
endinterface

[rtl/pitman_yor_table_seater_unit.sv]
// Pitman-Yor table seater, top level.
// Depends on pyts_pkg, pyts_in_if, pyts_out_if, pyts_store and the assertion header.
//
// Usage: each word on i_in is one customer with a 32-bit uniform random word
// and a candidate dish. The block draws a table from the Pitman-Yor seating
// weights and returns one word on o_out: the table index, its dish, and flags
// telling whether a new table was opened or the store was found full.
// Concentration and discount are written through the i_cfg port; the user
// must do so only while the block is idle, which the block does not enforce.
// Register 0 is concentration (Q8.8), 1 is discount (Q0.16); others are ignored.
// A customer seated at an existing table has its result registered once the
// walk reaches that table; when the new-table entry wins, whether it opens a
// table or finds the store full, no walk is needed. The walk over the
// seat-count memory, one table per cycle on its single read port, sets the
// worst case; the block goes idle as the result is registered and only then
// accepts the next customer.
// The total weight comes from a running sum of all counts, so only one walk
// is needed. Reset empties the restaurant and restores the default
// registers; the stores need no clearing since only open tables are read.
// When the receiver stalls, the result waits in the output register while the
// next customer is accepted and worked out; that customer then holds in its
// final state, with its store write-back, until the output register drains.
`include "pitman_yor_table_seater_unit_assert.svh"

module pitman_yor_table_seater_unit
    import pyts_pkg::*;
#(
    parameter int MAX_TABLES = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    pyts_in_if.sink              i_in,
    pyts_out_if.source           o_out
);

    localparam int IDX_W = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
    localparam int N_W   = $clog2(MAX_TABLES + 1);
    localparam int SUM_W = COUNT_BITS + N_W;
    // Weights carry 16 fraction bits; one spare bit covers the discount terms.
    localparam int TOT_W = SUM_W + FRAC_BITS + 1;
    localparam int ND_W  = N_W + CFG_W;
    localparam logic [N_W-1:0] N_MAX = N_W'(MAX_TABLES);

    // Configuration and persistent state.
    logic [CFG_W-1:0] r_conc, r_disc;
    logic [N_W-1:0]   r_open;
    logic [SUM_W-1:0] r_sum;

    // Per-item working registers.
    t_state            r_state, n_state;
    logic [WORD_W-1:0] r_word;
    logic [DISH_W-1:0] r_dish_in;
    logic [ND_W-1:0]   r_nd;
    logic [TOT_W-1:0]  r_total, r_base, r_thr, r_cum;
    logic [63:0]       r_prod;
    logic [31:0]       r_lo_part;
    logic [N_W-1:0]    r_rd_k;
    logic              r_dvalid;
    logic [IDX_W-1:0]  r_dk;
    logic              r_hit;
    logic [IDX_W-1:0]  r_pick;
    logic [COUNT_BITS-1:0] r_pick_cnt;
    logic [DISH_W-1:0] r_pick_dish;

    // Output register.
    logic              r_out_valid;
    logic [TIDX_W-1:0] r_out_idx;
    logic [DISH_W-1:0] r_out_dish;
    logic              r_out_new, r_out_full;

    // Store interface.
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [DISH_W-1:0]     rd_dish;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] wr_count;
    logic [DISH_W-1:0]     wr_dish;

    // Datapath signals.
    logic              accept;
    logic              fire;
    logic              fire_new;
    logic              cnt_room;
    logic [63:0]       total64;
    logic [31:0]       mul_a;
    logic [63:0]       mul_p;
    logic [63:0]       thr64;
    logic [TOT_W-1:0]  thr_now;
    logic [TOT_W-1:0]  cum_next;
    logic              hit_now;
    logic              last_now;
    logic              start_scan;
    logic [IDX_W+TIDX_W-1:0] pick_ext, open_ext;

    pyts_store #(
        .MAX_TABLES (MAX_TABLES),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_count (rd_cnt),
        .o_rd_dish  (rd_dish),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_count (wr_count),
        .i_wr_dish  (wr_dish)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && (r_state == S_IDLE);

    // One 32x32 multiplier serves both halves of the threshold product.
    assign total64 = 64'(r_total);
    assign mul_a   = (r_state == S_MUL_HI) ? total64[63:32] : total64[31:0];
    assign mul_p   = 64'(mul_a) * 64'(r_word);
    assign thr64   = r_prod + 64'(r_lo_part);
    assign thr_now = thr64[TOT_W-1:0];

    // Each open table adds its count minus the discount to the running weight.
    assign cum_next = r_cum + TOT_W'({rd_cnt, {FRAC_BITS{1'b0}}}) - TOT_W'(r_disc);
    assign hit_now  = r_dvalid && (cum_next > r_thr);
    assign last_now = r_dvalid && (N_W'(r_dk) == (r_open - N_W'(1)));

    assign start_scan = !(r_base > thr_now) && (r_open != '0);
    assign fire       = (r_state == S_FINISH) && (!r_out_valid || o_out.ready);
    assign fire_new   = fire && !r_hit && (r_open != N_MAX);
    assign cnt_room   = (r_pick_cnt != {COUNT_BITS{1'b1}});

    assign rd_addr  = r_rd_k[IDX_W-1:0];
    assign wr_en    = fire && (r_hit ? cnt_room : (r_open != N_MAX));
    assign wr_addr  = r_hit ? r_pick : r_open[IDX_W-1:0];
    assign wr_count = r_hit ? (r_pick_cnt + COUNT_BITS'(1)) : COUNT_BITS'(1);
    assign wr_dish  = r_hit ? r_pick_dish : r_dish_in;

    // The reported index keeps only its low six bits.
    assign pick_ext = (IDX_W + TIDX_W)'(r_pick);
    assign open_ext = (IDX_W + TIDX_W)'(r_open[IDX_W-1:0]);

    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_PREP;
            end
            S_PREP:   n_state = S_MUL_LO;
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_THR;
            S_THR: begin
                if (start_scan) begin
                    rd_en   = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SCAN: begin
                rd_en = !hit_now && (r_rd_k < r_open);
                if (hit_now || last_now) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (fire) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_conc      <= CONC_RESET;
            r_disc      <= DISC_RESET;
            r_open      <= '0;
            r_sum       <= '0;
            r_dvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dvalid <= rd_en;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CONCENTRATION: r_conc <= i_cfg_data;
                    CFG_DISCOUNT:      r_disc <= i_cfg_data;
                    default: ;
                endcase
            end
            if (wr_en) r_sum <= r_sum + SUM_W'(1);
            if (fire_new) r_open <= r_open + N_W'(1);
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word    <= i_in.uniform_word;
            r_dish_in <= i_in.base_dish;
            r_rd_k    <= '0;
        end
        if (r_state == S_PREP) begin
            r_nd    <= ND_W'(r_open) * ND_W'(r_disc);
            r_total <= TOT_W'({r_sum, {FRAC_BITS{1'b0}}}) + TOT_W'({r_conc, 8'b0});
        end
        if (r_state == S_MUL_LO) begin
            r_base <= TOT_W'({r_conc, 8'b0}) + TOT_W'(r_nd);
            r_prod <= mul_p;
        end
        if (r_state == S_MUL_HI) begin
            r_lo_part <= r_prod[63:32];
            r_prod    <= mul_p;
        end
        if (r_state == S_THR) begin
            r_thr <= thr_now;
            r_cum <= r_base;
            r_hit <= 1'b0;
        end
        if (rd_en) begin
            r_rd_k <= r_rd_k + N_W'(1);
            r_dk   <= rd_addr;
        end
        if ((r_state == S_SCAN) && r_dvalid) begin
            r_cum <= cum_next;
            if (hit_now) begin
                r_hit       <= 1'b1;
                r_pick      <= r_dk;
                r_pick_cnt  <= rd_cnt;
                r_pick_dish <= rd_dish;
            end
        end
        if (fire) begin
            if (r_hit) begin
                r_out_idx  <= pick_ext[TIDX_W-1:0];
                r_out_dish <= r_pick_dish;
                r_out_new  <= 1'b0;
                r_out_full <= 1'b0;
            end else if (r_open != N_MAX) begin
                r_out_idx  <= open_ext[TIDX_W-1:0];
                r_out_dish <= r_dish_in;
                r_out_new  <= 1'b1;
                r_out_full <= 1'b0;
            end else begin
                r_out_idx  <= '0;
                r_out_dish <= '0;
                r_out_new  <= 1'b0;
                r_out_full <= 1'b1;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.table_index = r_out_idx;
    assign o_out.dish_value  = r_out_dish;
    assign o_out.opened_new  = r_out_new;
    assign o_out.store_full  = r_out_full;

    // Only open tables may be read, so never-written entries stay unseen.
    `PYTS_ASSERT_HOLD(a_read_open, !rd_en || (N_W'(rd_addr) < r_open), "read beyond open tables")
    `PYTS_ASSERT_HOLD(a_open_bound, r_open <= N_MAX, "open table count overflow")
    `PYTS_ASSERT_NEXT(a_open_grow, fire_new, r_open == $past(r_open) + N_W'(1), "open count did not grow")
    `PYTS_ASSERT_HOLD(a_full_flag, !(r_out_valid && r_out_full) || (r_open == N_MAX), "full flag while room left")

endmodule

[rtl/pyts_store.sv]
// Per-table storage: seat counts and dishes, one read and one write port.
// Depends on pyts_pkg; read data comes in the cycle after the address.
module pyts_store
    import pyts_pkg::*;
#(
    parameter int MAX_TABLES = 64,
    parameter int COUNT_BITS = 16,
    parameter int IDX_W      = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [IDX_W-1:0]      i_rd_addr,
    output logic [COUNT_BITS-1:0] o_rd_count,
    output logic [DISH_W-1:0]     o_rd_dish,
    input  logic                  i_wr_en,
    input  logic [IDX_W-1:0]      i_wr_addr,
    input  logic [COUNT_BITS-1:0] i_wr_count,
    input  logic [DISH_W-1:0]     i_wr_dish
);

    logic [COUNT_BITS-1:0] r_count_mem [MAX_TABLES];
    logic [DISH_W-1:0]     r_dish_mem  [MAX_TABLES];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_count_mem[i_wr_addr] <= i_wr_count;
            r_dish_mem[i_wr_addr]  <= i_wr_dish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_count <= r_count_mem[i_rd_addr];
            o_rd_dish  <= r_dish_mem[i_rd_addr];
        end
    end

endmodule

[sim/pitman_yor_table_seater_unit_tb.sv]
// Self-checking testbench for the Pitman-Yor table seater top level.
// Depends on pyts_pkg, pyts_in_if, pyts_out_if and the RTL of the block.
// A directed table runs first, then random phases, then a final run without idling.
`timescale 1ns / 1ps

module pitman_yor_table_seater_unit_tb;
    import pyts_pkg::*;

    localparam int NUM_TABLES    = 64;
    localparam int SEAT_MAX      = 16'hFFFF;
    // Worst case for one customer is a full walk plus the overhead states.
    localparam int SETTLE_CYCLES = NUM_TABLES + 16;
    // The slowest correct run is roughly 1.8k customers, each counting a full walk,
    // a stall burst on each side and the handshake, plus the register drains and the
    // long hold-off. The limit takes that several times over.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 210;
    localparam int SAT_ITEMS     = 64;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 400;

    // Register indexes outside the list; the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [TIDX_W-1:0] tidx;
        logic [DISH_W-1:0] dish;
        logic              opened;
        logic              full;
    } t_seat;

    // One row of the directed table: either a register write or a customer.
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        logic [WORD_W-1:0]    word;
        logic [DISH_W-1:0]    dish;
        bit                   typed;
        t_seat                seat;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    pyts_in_if  cust_if ();
    pyts_out_if seat_if ();

    pitman_yor_table_seater_unit #(
        .MAX_TABLES (NUM_TABLES),
        .COUNT_BITS (16)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (cust_if),
        .o_out      (seat_if)
    );

    // Shadow of the restaurant: seat counts, dishes, open tables and both registers.
    logic [15:0]       table_seats [NUM_TABLES];
    logic [DISH_W-1:0] table_dish  [NUM_TABLES];
    int                tables_open;
    logic [CFG_W-1:0]  conc_r;
    logic [CFG_W-1:0]  disc_r;

    // Seatings that the block still owes, oldest first.
    t_seat seat_q[$];

    // Rows of the directed table, in the order they run.
    t_dir_row dir_rows[$];

    int  mismatches   = 0;
    int  results_seen = 0;
    int  cycle_count  = 0;
    bit  idle_on      = 1'b1;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Runaway guard: a hung handshake must still end the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Seats one customer in the shadow restaurant and returns what the block should
    // report. Weights carry 16 fraction bits: theta is Q8.8 so it moves up by 8, and
    // counts are whole numbers so they move up by 16. The threshold is the exact
    // floor of total times word over 2^32.
    function automatic t_seat seat_customer(input logic [WORD_W-1:0] w,
                                            input logic [DISH_W-1:0] dsh);
        logic [63:0] new_wt;
        logic [63:0] total;
        logic [63:0] cum;
        logic [95:0] prod;
        logic [63:0] thr;
        bit          hit;
        int          pick;
        t_seat       s;
        new_wt = {40'd0, conc_r, 8'd0} + 64'(tables_open) * 64'(disc_r);
        total  = new_wt;
        for (int k = 0; k < tables_open; k++)
            total += {32'd0, table_seats[k], 16'd0} - 64'(disc_r);
        prod = 96'(total) * 96'(w);
        thr  = prod[95:32];
        // The new-table entry comes first; only if it does not cover the threshold
        // does the walk over the open tables begin.
        cum  = new_wt;
        hit  = 1'b0;
        pick = 0;
        if (!(cum > thr)) begin
            for (int k = 0; k < tables_open; k++) begin
                if (!hit) begin
                    cum += {32'd0, table_seats[k], 16'd0} - 64'(disc_r);
                    if (cum > thr) begin
                        hit  = 1'b1;
                        pick = k;
                    end
                end
            end
        end
        if (hit) begin
            // Counts saturate rather than wrap.
            if (table_seats[pick] != SEAT_MAX[15:0])
                table_seats[pick] = table_seats[pick] + 16'd1;
            s = '{tidx: TIDX_W'(pick), dish: table_dish[pick], opened: 1'b0, full: 1'b0};
        end else if (tables_open < NUM_TABLES) begin
            table_seats[tables_open] = 16'd1;
            table_dish[tables_open]  = dsh;
            s = '{tidx: TIDX_W'(tables_open), dish: dsh, opened: 1'b1, full: 1'b0};
            tables_open++;
        end else begin
            // A new-table draw with every slot taken leaves the state alone.
            s = '{tidx: '0, dish: '0, opened: 1'b0, full: 1'b1};
        end
        return s;
    endfunction

    function automatic void flag_mismatch(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s at result %0d: expected %h, got %h",
                     field, results_seen, want, got);
    endfunction

    function automatic logic [CFG_W-1:0] pick_setting();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'd1;
            2:       return CONC_RESET;
            3:       return 16'hFFFF;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    function automatic logic [DISH_W-1:0] rand_dish();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return DISH_W'($urandom);
        endcase
    endfunction

    function automatic t_dir_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] data);
        t_dir_row r;
        r        = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic t_dir_row item_row(input logic [WORD_W-1:0] w,
                                          input logic [DISH_W-1:0] dsh);
        t_dir_row r;
        r      = '{default: '0};
        r.word = w;
        r.dish = dsh;
        return r;
    endfunction

    function automatic t_dir_row typed_row(input logic [WORD_W-1:0] w,
                                           input logic [DISH_W-1:0] dsh,
                                           input t_seat s);
        t_dir_row r;
        r       = item_row(w, dsh);
        r.typed = 1'b1;
        r.seat  = s;
        return r;
    endfunction

    // Adds one row at the end of the directed table.
    function automatic void append_row(input t_dir_row r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // Drops valid, waits until every owed seating has come back, then waits out the
    // settle period, which covers a full walk, for the block to go quiet.
    task automatic settle_block();
        @(negedge i_clk);
        cust_if.valid <= 1'b0;
        while (seat_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Registers change only with the block idle, so each write drains first.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] data);
        settle_block();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_CONCENTRATION)
            conc_r = data;
        else if (idx == CFG_DISCOUNT)
            disc_r = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offers one customer word and books the seating it should cause once the
    // block takes it. Valid stays high after acceptance so back-to-back words need
    // no gap; the next call or settle_block decides what happens to it.
    task automatic seat_one(input logic [WORD_W-1:0] w, input logic [DISH_W-1:0] dsh,
                            input bit typed, input t_seat typed_seat);
        int    gap;
        t_seat pred;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            cust_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cust_if.valid        <= 1'b1;
        cust_if.uniform_word <= w;
        cust_if.base_dish    <= dsh;
        do @(posedge i_clk); while (!cust_if.ready);
        pred = seat_customer(w, dsh);
        seat_q.insert(seat_q.size(), typed ? typed_seat : pred);
    endtask

    // Receiver: short random stall bursts, plus one long hold-off once a few hundred
    // seatings have come back, while the sender keeps offering words.
    initial begin : result_sink
        int  stall_left;
        int  hold_left;
        bit  hold_done;
        stall_left    = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        seat_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                seat_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                seat_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                seat_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                seat_if.ready <= 1'b0;
            end else begin
                seat_if.ready <= 1'b1;
            end
        end
    end

    // Every accepted seating word is held against the oldest one still owed.
    always @(posedge i_clk) begin : seat_monitor
        t_seat want;
        if (i_rst_n && seat_if.valid && seat_if.ready) begin
            results_seen++;
            if (seat_q.size() == 0) begin
                flag_mismatch("unexpected word", '0,
                              64'({seat_if.table_index, seat_if.dish_value}));
            end else begin
                want = seat_q.pop_front();
                if (seat_if.table_index !== want.tidx)
                    flag_mismatch("table_index", 64'(want.tidx), 64'(seat_if.table_index));
                if (seat_if.dish_value !== want.dish)
                    flag_mismatch("dish_value", 64'(want.dish), 64'(seat_if.dish_value));
                if (seat_if.opened_new !== want.opened)
                    flag_mismatch("opened_new", 64'(want.opened), 64'(seat_if.opened_new));
                if (seat_if.store_full !== want.full)
                    flag_mismatch("store_full", 64'(want.full), 64'(seat_if.store_full));
            end
        end
    end

    initial begin : stimulus
        t_dir_row          r;
        logic [WORD_W-1:0] w;
        logic [CFG_W-1:0]  c_set;
        logic [CFG_W-1:0]  d_set;
        int                small_odds;

        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        cust_if.valid        = 1'b0;
        cust_if.uniform_word = '0;
        cust_if.base_dish    = '0;
        conc_r               = CONC_RESET;
        disc_r               = DISC_RESET;
        tables_open          = 0;
        for (int k = 0; k < NUM_TABLES; k++) begin
            table_seats[k] = '0;
            table_dish[k]  = '0;
        end

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. With theta zero and an empty restaurant the total weight is
        // zero, so the first customer must open table 0 whatever its word. With one
        // table and theta zero, word zero must then seat at that table. With theta
        // and discount at their maxima, word zero always opens a new table.
        append_row(cfg_row(CFG_CONCENTRATION, 16'd0));
        append_row(typed_row(32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             '{tidx: 6'd0, dish: 32'hFFFF_FFFF, opened: 1'b1, full: 1'b0}));
        append_row(typed_row(32'h0000_0000, 32'h0000_0000,
                             '{tidx: 6'd0, dish: 32'hFFFF_FFFF, opened: 1'b0, full: 1'b0}));
        append_row(item_row(32'hFFFF_FFFF, 32'h1234_5678));
        append_row(cfg_row(CFG_CONCENTRATION, 16'hFFFF));
        append_row(cfg_row(CFG_DISCOUNT, 16'hFFFF));
        append_row(typed_row(32'h0000_0000, 32'h0000_0000,
                             '{tidx: 6'd1, dish: 32'h0000_0000, opened: 1'b1, full: 1'b0}));
        append_row(item_row(32'hFFFF_FFFF, 32'hA5A5_A5A5));
        append_row(item_row(32'h8000_0000, 32'h5A5A_5A5A));
        // Writes to indexes past the register list must leave both registers alone.
        append_row(cfg_row(CFG_UNUSED_LO, 16'h1234));
        append_row(cfg_row(CFG_UNUSED_HI, 16'hFFFF));
        append_row(item_row(32'h0000_0001, 32'hFFFF_FFFF));
        append_row(cfg_row(CFG_CONCENTRATION, CONC_RESET));
        append_row(cfg_row(CFG_DISCOUNT, DISC_RESET));
        append_row(item_row(32'hC000_0000, 32'h0F0F_0F0F));
        append_row(item_row(32'h4000_0000, 32'hF0F0_F0F0));
        append_row(cfg_row(CFG_CONCENTRATION, 16'd1));
        append_row(cfg_row(CFG_DISCOUNT, 16'd1));
        append_row(item_row(32'hFFFF_FFFF, 32'h0000_0001));
        append_row(item_row(32'h0000_0000, 32'h8000_0000));

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.is_cfg)
                write_register(r.idx, r.data);
            else
                seat_one(r.word, r.dish, r.typed, r.seat);
        end

        // Random phases, each under its own register setting. Small words aim at the
        // new-table entry, so the restaurant fills up over the run and later phases
        // see full-store draws; words near the top reach the last open tables.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            idle_on    = (ph != 3);
            small_odds = 12;
            case (ph)
                1: begin
                    c_set = 16'd0;
                    d_set = 16'hFFFF;
                end
                2: begin
                    c_set = 16'hFFFF;
                    d_set = 16'd0;
                end
                6: begin
                    // Pushes the store to full if it is not already.
                    c_set      = 16'hFFFF;
                    d_set      = 16'hFFFF;
                    small_odds = 2;
                end
                default: begin
                    c_set = pick_setting();
                    d_set = pick_setting();
                end
            endcase
            write_register(CFG_CONCENTRATION, c_set);
            write_register(CFG_DISCOUNT, d_set);
            if (ph == 5)
                write_register(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                               CFG_W'($urandom));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(1, small_odds) == 1)
                    w = WORD_W'($urandom_range(0, 255));
                else begin
                    case ($urandom_range(0, 11))
                        0:       w = 32'hFFFF_FF00 | WORD_W'($urandom_range(0, 255));
                        1:       w = '0;
                        2:       w = '1;
                        default: w = WORD_W'($urandom);
                    endcase
                end
                seat_one(w, rand_dish(), 1'b0, '0);
            end
        end

        // Final run with no idling on either side. With theta and discount both zero
        // the new-table entry weighs nothing, and a word below 256 keeps the threshold
        // under one seat, so every customer lands on table 0 back to back.
        idle_on = 1'b0;
        write_register(CFG_CONCENTRATION, 16'd0);
        write_register(CFG_DISCOUNT, 16'd0);
        for (int i = 0; i < SAT_ITEMS; i++)
            seat_one(WORD_W'($urandom_range(0, 255)), rand_dish(), 1'b0, '0);

        settle_block();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/pyts_pkg.sv
rtl/pyts_in_if.sv
rtl/pyts_out_if.sv
rtl/pyts_store.sv
rtl/pitman_yor_table_seater_unit.sv
sim/pitman_yor_table_seater_unit_tb.sv
